@@ sv/pms_pkg.sv @@
package pms_pkg;

  // Default coordinate width of the input points.
  localparam int COORD_BITS_DEF = 16;

  // Widths of the arithmetic units.
  localparam int NORM_W    = 33;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int DIV_NUM_W = 45;
  localparam int DIV_DEN_W = 34;

  // Register values after reset.
  localparam logic [24:0] SCALE_RST = 25'd4096;
  localparam logic [31:0] BASE_RST  = 32'd0;
  localparam logic [15:0] HW_RST    = 16'd0;
  localparam logic [31:0] COL_RST   = 32'hFFFF_FFFF;

  // Register map, one word per register.
  typedef enum logic [1:0] {
    REG_SCALE,
    REG_BASE,
    REG_HW,
    REG_COL
  } reg_e;

  // Sequencer states of the top level.
  typedef enum logic [4:0] {
    S_IDLE,
    S_NORM,
    S_SQA,
    S_SQB,
    S_SQRT_GO,
    S_SQRT_W,
    S_DX_GO,
    S_DX_W,
    S_DY_GO,
    S_DY_W,
    S_MA,
    S_MB,
    S_MC,
    S_MD,
    S_ME,
    S_MF,
    S_MG,
    S_MX_GO,
    S_MX_W,
    S_MY_GO,
    S_MY_W,
    S_EMIT,
    S_PX,
    S_PY
  } state_e;

endpackage

@@ sv/pms_sqrt.sv @@
module pms_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pms_pkg::RAD_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [pms_pkg::ROOT_W-1:0]  root_o
);

  localparam int RootW = pms_pkg::ROOT_W;
  localparam int RadW  = pms_pkg::RAD_W;
  localparam int RemW  = RootW + 4;
  localparam int CntW  = $clog2(RootW + 1);

  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;
  logic             ge;

  // One result bit per cycle: bring in two radicand bits and try 4r+1.
  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ sv/pms_div.sv @@
module pms_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pms_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [pms_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [pms_pkg::DIV_NUM_W-1:0]  quo_o
);

  localparam int NumW = pms_pkg::DIV_NUM_W;
  localparam int DenW = pms_pkg::DIV_DEN_W;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DenW:0]   rem_sh;
  logic            ge;

  // Restoring division, one quotient bit per cycle shifted into num_q.
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], ge};
      rem_q <= ge ? DenW'(rem_sh - {1'b0, den_q}) : DenW'(rem_sh);
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

@@ sv/polyline_mitre_stroke.sv @@
// Mitre-join stroke expansion of a polyline. Points enter one beat at a time on the
// input channel, with end_of_line on the last one; a point equal to the one held
// before it is dropped. Every kept point yields one result beat with its scaled
// position (Q28.12), its join normal (Q3.12) and its plus-normal vertex index; the
// result of a point leaves once the next distinct point has arrived, and the last
// point's result follows on the end_of_line beat. The input is held off while a
// distinct point is worked on: the delta normalization shifts one bit a cycle,
// the segment length comes from a bit-serial square root, each normal or mitre
// component from a restoring divider (two quotients per point, four at a mitre,
// after the mitre setup), and each result passes through the output register,
// plus any wait for the previous result to be taken. A repeated point uses
// neither the square root nor the divider.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12:
// coord_scale, index_base, line_half_width, line_colour.
module polyline_mitre_stroke #(
  parameter int COORD_BITS = pms_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         end_of_line_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [39:0]           pos_x_o,
  output logic signed [39:0]           pos_y_o,
  output logic signed [15:0]           normal_x_o,
  output logic signed [15:0]           normal_y_o,
  output logic [31:0]                  vertex_index_o,
  output logic                         has_quad_o,
  output logic                         final_point_o,
  output logic [15:0]                  vertex_half_width_o,
  output logic [31:0]                  vertex_colour_o
);

  localparam int CB    = COORD_BITS;
  localparam int PW    = CB + 26;
  localparam int NormW = pms_pkg::NORM_W;
  localparam int NumW  = pms_pkg::DIV_NUM_W;
  localparam int DenW  = pms_pkg::DIV_DEN_W;

  pms_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [24:0] scale_q;
  logic [31:0] base_q;
  logic [15:0] hw_q;
  logic [31:0] col_q;

  // Line state.
  logic signed [CB-1:0] held_x_q, held_y_q;
  logic signed [15:0]   inx_q, iny_q;
  logic [31:0]          kept_q;

  // Working registers of one point.
  logic signed [CB-1:0] cur_x_q, cur_y_q;
  logic                 eol_q;
  logic                 sgn_nx_q, sgn_ny_q;
  logic [NormW-1:0]     ax_q, ay_q;
  logic [62:0]          acc_q;
  logic [31:0]          len_q;
  logic [15:0]          cx_q;
  logic signed [15:0]   sx_q, sy_q, jx_q, jy_q;
  logic signed [16:0]   mx_q, my_q;
  logic signed [33:0]   d_q;
  logic [34:0]          m2_q;
  logic [51:0]          dd_q;

  // Pending result and the optional second one.
  logic signed [CB-1:0] r_x_q, r_y_q;
  logic signed [15:0]   r_nx_q, r_ny_q;
  logic [31:0]          r_cnt_q, r2_cnt_q;
  logic                 r_fin_q, pend2_q;

  // Output register.
  logic                 out_valid_q;
  logic signed [39:0]   pos_x_q, pos_y_q;
  logic signed [15:0]   onx_q, ony_q;
  logic [31:0]          oidx_q;
  logic                 ofin_q;
  logic [15:0]          ohw_q;
  logic [31:0]          ocol_q;

  // Unit handshakes and operands.
  logic             sqrt_start, sqrt_done;
  logic [31:0]      sqrt_root;
  logic             div_start, div_done;
  logic [NumW-1:0]  div_num, div_quo;
  logic [DenW-1:0]  div_den;

  logic                 in_acc, cfg_wr;
  logic signed [CB:0]   dx, dy;
  logic [CB:0]          dx_abs, dy_abs;
  logic                 same_pt;
  logic [31:0]          kept_new;
  logic [NormW-1:0]     nmax;
  logic signed [15:0]   quo16, nx_new, ny_new, mq_x, mq_y;
  logic [16:0]          amx, amy;
  logic                 m_zero, d_nonpos, lim_exceed;
  logic [31:0]          cnt_m1;

  // Shared products.
  logic [30:0]          sq_op;
  logic [61:0]          sq_prod;
  logic signed [33:0]   d_prod;
  logic [34:0]          m_prod;
  logic signed [PW-1:0] pos_prod;

  function automatic logic [39:0] sat_pos(input logic signed [PW-1:0] p);
    logic signed [63:0] w;
    w = 64'(p);
    if (w > 64'sd549755813887) begin
      sat_pos = 40'h7F_FFFF_FFFF;
    end else if (w < -64'sd549755813888) begin
      sat_pos = 40'h80_0000_0000;
    end else begin
      sat_pos = w[39:0];
    end
  endfunction

  assign in_acc = in_valid_i && in_ready_o;
  assign cfg_wr = psel && penable && pwrite;

  // Segment delta against the held point.
  assign dx      = $signed({point_x_i[CB-1], point_x_i}) - $signed({held_x_q[CB-1], held_x_q});
  assign dy      = $signed({point_y_i[CB-1], point_y_i}) - $signed({held_y_q[CB-1], held_y_q});
  assign dx_abs  = dx[CB] ? -dx : dx;
  assign dy_abs  = dy[CB] ? -dy : dy;
  assign same_pt = (point_x_i == held_x_q) && (point_y_i == held_y_q);

  // The count wraps into the upper half so that it never returns to zero.
  assign kept_new = (kept_q == 32'hFFFF_FFFF) ? 32'h8000_0001 : kept_q + 32'd1;
  assign nmax     = (ax_q > ay_q) ? ax_q : ay_q;

  // Sign handling of divider quotients.
  assign quo16  = div_quo[15:0];
  assign nx_new = sgn_nx_q ? -$signed(cx_q) : $signed(cx_q);
  assign ny_new = sgn_ny_q ? -quo16 : quo16;
  assign mq_x   = mx_q[16] ? -quo16 : quo16;
  assign mq_y   = my_q[16] ? -quo16 : quo16;
  assign amx    = mx_q[16] ? -mx_q : mx_q;
  assign amy    = my_q[16] ? -my_q : my_q;

  // Products of the length, mitre and position steps.
  assign sq_op    = (state_q == pms_pkg::S_SQA) ? ax_q[30:0] : ay_q[30:0];
  assign sq_prod  = sq_op * sq_op;
  assign d_prod   = (state_q == pms_pkg::S_MB) ? mx_q * sx_q : my_q * sy_q;
  assign m_prod   = (state_q == pms_pkg::S_MD) ? amx * amx : amy * amy;
  assign pos_prod = ((state_q == pms_pkg::S_PY) ? r_y_q : r_x_q) *
                    $signed({1'b0, scale_q});

  // Bevel decisions. Normals are unit vectors, so d stays below 2^26.
  assign m_zero     = (mx_q == 17'sd0) && (my_q == 17'sd0);
  assign d_nonpos   = d_q[33] || (d_q == 34'sd0);
  assign lim_exceed = ({m2_q, 24'b0} > 59'({dd_q, 4'b0}));
  assign cnt_m1     = r_cnt_q - 32'd1;

  pms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({1'b0, acc_q}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  pms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state and unit launches.
  always_comb begin
    state_d    = state_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    div_num    = NumW'({ay_q[30:0], 12'b0}) + NumW'(len_q[31:1]);
    div_den    = DenW'(len_q);
    unique case (state_q)
      pms_pkg::S_IDLE: begin
        if (in_acc && (kept_q != 32'd0)) begin
          if (!same_pt) begin
            state_d = pms_pkg::S_NORM;
          end else if (end_of_line_i && (kept_q > 32'd1)) begin
            state_d = pms_pkg::S_PX;
          end
        end
      end
      pms_pkg::S_NORM: begin
        if (nmax[NormW-1:30] == '0) begin
          state_d = pms_pkg::S_NORM;
        end else if (nmax[NormW-1:31] != '0) begin
          state_d = pms_pkg::S_NORM;
        end else begin
          state_d = pms_pkg::S_SQA;
        end
      end
      pms_pkg::S_SQA:     state_d = pms_pkg::S_SQB;
      pms_pkg::S_SQB:     state_d = pms_pkg::S_SQRT_GO;
      pms_pkg::S_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_d    = pms_pkg::S_SQRT_W;
      end
      pms_pkg::S_SQRT_W: begin
        if (sqrt_done) begin
          state_d = pms_pkg::S_DX_GO;
        end
      end
      pms_pkg::S_DX_GO: begin
        div_start = 1'b1;
        state_d   = pms_pkg::S_DX_W;
      end
      pms_pkg::S_DX_W: begin
        if (div_done) begin
          state_d = pms_pkg::S_DY_GO;
        end
      end
      pms_pkg::S_DY_GO: begin
        div_start = 1'b1;
        div_num   = NumW'({ax_q[30:0], 12'b0}) + NumW'(len_q[31:1]);
        state_d   = pms_pkg::S_DY_W;
      end
      pms_pkg::S_DY_W: begin
        if (div_done) begin
          state_d = (kept_q == 32'd1) ? pms_pkg::S_EMIT : pms_pkg::S_MA;
        end
      end
      pms_pkg::S_MA: state_d = pms_pkg::S_MB;
      pms_pkg::S_MB: state_d = pms_pkg::S_MC;
      pms_pkg::S_MC: state_d = pms_pkg::S_MD;
      pms_pkg::S_MD: state_d = pms_pkg::S_ME;
      pms_pkg::S_ME: state_d = pms_pkg::S_MF;
      pms_pkg::S_MF: begin
        state_d = (m_zero || d_nonpos) ? pms_pkg::S_EMIT : pms_pkg::S_MG;
      end
      pms_pkg::S_MG: begin
        state_d = lim_exceed ? pms_pkg::S_EMIT : pms_pkg::S_MX_GO;
      end
      pms_pkg::S_MX_GO: begin
        div_start = 1'b1;
        div_num   = NumW'({amx, 24'b0}) + NumW'(d_q[33:1]);
        div_den   = DenW'(d_q);
        state_d   = pms_pkg::S_MX_W;
      end
      pms_pkg::S_MX_W: begin
        if (div_done) begin
          state_d = pms_pkg::S_MY_GO;
        end
      end
      pms_pkg::S_MY_GO: begin
        div_start = 1'b1;
        div_num   = NumW'({amy, 24'b0}) + NumW'(d_q[33:1]);
        div_den   = DenW'(d_q);
        state_d   = pms_pkg::S_MY_W;
      end
      pms_pkg::S_MY_W: begin
        if (div_done) begin
          state_d = pms_pkg::S_EMIT;
        end
      end
      pms_pkg::S_EMIT: state_d = pms_pkg::S_PX;
      pms_pkg::S_PX: begin
        if (!out_valid_q) begin
          state_d = pms_pkg::S_PY;
        end
      end
      pms_pkg::S_PY: begin
        state_d = pend2_q ? pms_pkg::S_PX : pms_pkg::S_IDLE;
      end
      default: state_d = pms_pkg::S_IDLE;
    endcase
  end

  // State, line state, configuration and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pms_pkg::S_IDLE;
      scale_q     <= pms_pkg::SCALE_RST;
      base_q      <= pms_pkg::BASE_RST;
      hw_q        <= pms_pkg::HW_RST;
      col_q       <= pms_pkg::COL_RST;
      held_x_q    <= '0;
      held_y_q    <= '0;
      inx_q       <= '0;
      iny_q       <= '0;
      kept_q      <= '0;
      pend2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (pms_pkg::reg_e'(paddr[3:2]))
          pms_pkg::REG_SCALE: scale_q <= pwdata[24:0];
          pms_pkg::REG_BASE:  base_q  <= pwdata;
          pms_pkg::REG_HW:    hw_q    <= pwdata[15:0];
          pms_pkg::REG_COL:   col_q   <= pwdata;
        endcase
      end
      if (state_q == pms_pkg::S_PY) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Accepted point: hold the first one unless it ends the line, or close the line on a repeat that ends it.
      if (in_acc) begin
        if (kept_q == 32'd0) begin
          if (!end_of_line_i) begin
            held_x_q <= point_x_i;
            held_y_q <= point_y_i;
            kept_q   <= 32'd1;
          end
        end else if (same_pt && end_of_line_i) begin
          pend2_q  <= 1'b0;
          held_x_q <= '0;
          held_y_q <= '0;
          inx_q    <= '0;
          iny_q    <= '0;
          kept_q   <= '0;
        end
      end
      // Commit the segment, or clear the line after its last point.
      if (state_q == pms_pkg::S_EMIT) begin
        pend2_q <= eol_q;
        if (eol_q) begin
          held_x_q <= '0;
          held_y_q <= '0;
          inx_q    <= '0;
          iny_q    <= '0;
          kept_q   <= '0;
        end else begin
          held_x_q <= cur_x_q;
          held_y_q <= cur_y_q;
          inx_q    <= sx_q;
          iny_q    <= sy_q;
          kept_q   <= kept_new;
        end
      end
      if (state_q == pms_pkg::S_PY) begin
        pend2_q <= 1'b0;
      end
    end
  end

  // Point datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      pms_pkg::S_IDLE: begin
        if (in_acc) begin
          cur_x_q  <= point_x_i;
          cur_y_q  <= point_y_i;
          eol_q    <= end_of_line_i;
          ax_q     <= NormW'(dx_abs);
          ay_q     <= NormW'(dy_abs);
          sgn_nx_q <= !dy[CB] && (dy != '0);
          sgn_ny_q <= dx[CB];
          // Repeated last point goes out as the final result.
          r_x_q    <= held_x_q;
          r_y_q    <= held_y_q;
          r_nx_q   <= inx_q;
          r_ny_q   <= iny_q;
          r_cnt_q  <= kept_q;
          r_fin_q  <= 1'b1;
        end
      end
      pms_pkg::S_NORM: begin
        if (nmax[NormW-1:30] == '0) begin
          ax_q <= {ax_q[NormW-2:0], 1'b0};
          ay_q <= {ay_q[NormW-2:0], 1'b0};
        end else if (nmax[NormW-1:31] != '0) begin
          ax_q <= {1'b0, ax_q[NormW-1:1]};
          ay_q <= {1'b0, ay_q[NormW-1:1]};
        end
      end
      pms_pkg::S_SQA: acc_q <= {1'b0, sq_prod};
      pms_pkg::S_SQB: acc_q <= acc_q + {1'b0, sq_prod};
      pms_pkg::S_SQRT_W: begin
        if (sqrt_done) begin
          len_q <= sqrt_root;
        end
      end
      pms_pkg::S_DX_W: begin
        if (div_done) begin
          cx_q <= quo16;
        end
      end
      pms_pkg::S_DY_W: begin
        if (div_done) begin
          sx_q <= nx_new;
          sy_q <= ny_new;
          jx_q <= nx_new;
          jy_q <= ny_new;
        end
      end
      pms_pkg::S_MA: begin
        mx_q <= $signed({inx_q[15], inx_q}) + $signed({sx_q[15], sx_q});
        my_q <= $signed({iny_q[15], iny_q}) + $signed({sy_q[15], sy_q});
      end
      pms_pkg::S_MB: d_q  <= d_prod;
      pms_pkg::S_MC: d_q  <= d_q + d_prod;
      pms_pkg::S_MD: m2_q <= m_prod;
      pms_pkg::S_ME: m2_q <= m2_q + m_prod;
      pms_pkg::S_MF: dd_q <= d_q[25:0] * d_q[25:0];
      pms_pkg::S_MX_W: begin
        if (div_done) begin
          jx_q <= mq_x;
        end
      end
      pms_pkg::S_MY_W: begin
        if (div_done) begin
          jy_q <= mq_y;
        end
      end
      pms_pkg::S_EMIT: begin
        r_x_q    <= held_x_q;
        r_y_q    <= held_y_q;
        r_nx_q   <= jx_q;
        r_ny_q   <= jy_q;
        r_cnt_q  <= kept_q;
        r_fin_q  <= 1'b0;
        r2_cnt_q <= kept_new;
      end
      pms_pkg::S_PX: begin
        if (!out_valid_q) begin
          pos_x_q <= sat_pos(pos_prod);
          onx_q   <= r_nx_q;
          ony_q   <= r_ny_q;
          oidx_q  <= base_q + {cnt_m1[30:0], 1'b0};
          ofin_q  <= r_fin_q;
          ohw_q   <= hw_q;
          ocol_q  <= col_q;
        end
      end
      pms_pkg::S_PY: begin
        pos_y_q <= sat_pos(pos_prod);
        // Second result of a closing point: the new point itself.
        r_x_q   <= cur_x_q;
        r_y_q   <= cur_y_q;
        r_nx_q  <= sx_q;
        r_ny_q  <= sy_q;
        r_cnt_q <= r2_cnt_q;
        r_fin_q <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Register read-back.
  always_comb begin
    unique case (pms_pkg::reg_e'(paddr[3:2]))
      pms_pkg::REG_SCALE: prdata = {7'b0, scale_q};
      pms_pkg::REG_BASE:  prdata = base_q;
      pms_pkg::REG_HW:    prdata = {16'b0, hw_q};
      pms_pkg::REG_COL:   prdata = col_q;
    endcase
  end

  assign pready              = 1'b1;
  assign in_ready_o          = (state_q == pms_pkg::S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign pos_x_o             = pos_x_q;
  assign pos_y_o             = pos_y_q;
  assign normal_x_o          = onx_q;
  assign normal_y_o          = ony_q;
  assign vertex_index_o      = oidx_q;
  assign has_quad_o          = !ofin_q;
  assign final_point_o       = ofin_q;
  assign vertex_half_width_o = ohw_q;
  assign vertex_colour_o     = ocol_q;

`ifndef NO_ASSERTIONS
  // A result either joins to the next point or closes the line.
  a_quad_or_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (has_quad_o != final_point_o))
    else $error("result both joins and closes");

  // An empty line holds no point and no incoming normal.
  a_empty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_q == 32'd0) |-> ((held_x_q == '0) && (held_y_q == '0) &&
                           (inx_q == 16'sd0) && (iny_q == 16'sd0)))
    else $error("line state left over after clear");

  // The output register is only loaded while empty.
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pms_pkg::S_PY) |-> !out_valid_q)
    else $error("result overwritten before it was taken");

  // The line state changes only on an accepted beat or at a commit.
  a_kept_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc && (state_q != pms_pkg::S_EMIT)) |=> $stable(kept_q))
    else $error("point count changed outside a commit");
`endif

endmodule
